@@ sv/rsts_pkg.sv @@
// shared constants, widths and control structs of the rsi and trend slope core
package rsts_pkg;

    // window and indicator lengths
    localparam int PRICE_W      = 32;
    localparam int RSI_LEN      = 14;
    localparam int SLOPE_LEN    = 10;
    localparam int WINDOW_DEPTH = 16;

    // output formats
    localparam int RSI_W          = 23;
    localparam int SLOPE_W        = 32;
    localparam int FRAC_BITS      = 24;
    localparam int INT_BITS       = 7;
    localparam int RSI_FULL_SCALE = 6553600;
    localparam int RSI_HALF_SCALE = 3276800;
    localparam int RSI_PCT        = 100;
    localparam int RSI_FRAC_BITS  = 16;

    // scan geometry: positions run oldest first over the newest SCAN_LEN prices
    localparam int RSI_SPAN    = RSI_LEN + 1;
    localparam int SPAN_MAX    = (RSI_SPAN > SLOPE_LEN) ? RSI_SPAN : SLOPE_LEN;
    localparam int SCAN_LEN    = (SPAN_MAX < WINDOW_DEPTH) ? SPAN_MAX : WINDOW_DEPTH;
    localparam int RSI_START   = (SCAN_LEN > RSI_LEN) ? SCAN_LEN - 1 - RSI_LEN : 0;
    localparam int SLOPE_START = (SCAN_LEN >= SLOPE_LEN) ? SCAN_LEN - SLOPE_LEN : 0;

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W  = $clog2(SCAN_LEN);

    // rsi sums and division operands
    localparam int GL_W    = PRICE_W + $clog2(RSI_LEN + 1);
    localparam int G100_W  = GL_W + $clog2(RSI_PCT + 1);
    localparam int RSI_N_W = GL_W + RSI_W;
    localparam int RSI_Q_W = RSI_W;

    // regression constants over x = 0 .. n-1
    localparam int SX     = SLOPE_LEN * (SLOPE_LEN - 1) / 2;
    localparam int SX2    = (SLOPE_LEN - 1) * SLOPE_LEN * (2 * SLOPE_LEN - 1) / 6;
    localparam int DEN    = SLOPE_LEN * SX2 - SX * SX;
    localparam int IDX_W  = $clog2(SLOPE_LEN);
    localparam int SY_W   = PRICE_W + $clog2(SLOPE_LEN + 1);
    localparam int SXY_W  = PRICE_W + $clog2(SX + 1);
    localparam int NSXY_W = SXY_W + $clog2(SLOPE_LEN + 1);
    localparam int SXSY_W = SY_W + $clog2(SX + 1);
    localparam int MAG_W  = (NSXY_W > SXSY_W) ? NSXY_W : SXSY_W;
    localparam int NUM_W  = MAG_W + 1;
    localparam int A_W    = MAG_W + $clog2(SLOPE_LEN + 1);
    localparam int DEN_W  = $clog2(DEN + 1);
    localparam int B_W    = SY_W + DEN_W;
    localparam int SAT_W  = (A_W > B_W + INT_BITS) ? A_W : B_W + INT_BITS;
    localparam int SLOPE_Q_W = INT_BITS + FRAC_BITS;

    // shared serial divider geometry
    localparam int DIV_R_W   = (RSI_N_W > B_W + INT_BITS) ? RSI_N_W : B_W + INT_BITS;
    localparam int DIV_Q_W   = (SLOPE_Q_W > RSI_Q_W) ? SLOPE_Q_W : RSI_Q_W;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    // controller to datapath commands
    typedef struct packed {
        logic             accept;
        logic             scan_rd;
        logic [POS_W-1:0] scan_pos;
        logic             prep1;
        logic             prep2;
        logic             prep3;
        logic             prep4;
        logic             out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } dp_sts_t;

endpackage

@@ sv/rsts_div.sv @@
// serial restoring divider, one quotient bit per cycle
module rsts_div
    import rsts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_CNT_W-1:0] steps,
    input  logic [DIV_R_W-1:0]   rem_init,
    input  logic [DIV_R_W-1:0]   dvs_init,
    output logic                 busy,
    output logic [DIV_Q_W-1:0]   quo
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_R_W-1:0]   rem_reg, rem_next;
    logic [DIV_R_W-1:0]   dvs_reg;
    logic [DIV_Q_W-1:0]   quo_reg, quo_next;
    logic                 ge;
    logic [DIV_R_W-1:0]   diff;

    // compare, subtract and shift the partial remainder
    always_comb begin
        ge       = rem_reg >= dvs_reg;
        diff     = ge ? rem_reg - dvs_reg : rem_reg;
        rem_next = diff << 1;
        quo_next = {quo_reg[DIV_Q_W-2:0], ge};
    end

    // step counter
    always_comb begin
        if (start) begin
            cnt_next = steps;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // operand registers
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            dvs_reg <= dvs_init;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;

endmodule

@@ sv/rsts_dp.sv @@
// datapath: price window memory, scan accumulators, operand prep, dividers, result register
module rsts_dp
    import rsts_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dp_cmd_t                   cmd,
    output dp_sts_t                   sts,
    input  logic [PRICE_W-1:0]        s_close_price,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [RSI_W-1:0]          m_rsi_value,
    output logic signed [SLOPE_W-1:0] m_relative_slope,
    output logic                      m_slope_valid
);

    // window state
    logic [PRICE_W-1:0] window_mem [WINDOW_DEPTH];
    logic [ADDR_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [CNT_W-1:0]   sample_count_reg, sample_count_next;
    logic [ADDR_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [ADDR_W+1:0]  start_sum;
    logic [ADDR_W-1:0]  start_addr;

    // scan pipeline
    logic [PRICE_W-1:0] rd_data_reg;
    logic               rd_vld_reg;
    logic [POS_W-1:0]   rd_pos_reg;
    logic [PRICE_W-1:0] prev_reg;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W+PRICE_W-1:0] prod;

    // accumulators
    logic [GL_W-1:0]  gain_reg, loss_reg;
    logic [SY_W-1:0]  sy_reg;
    logic [SXY_W-1:0] sxy_reg;

    // prep registers
    logic [G100_W-1:0]  g100_reg;
    logic [GL_W-1:0]    total_reg, total_sum;
    logic [NSXY_W-1:0]  nsxy_reg;
    logic [SXSY_W-1:0]  sxsy_reg;
    logic [B_W-1:0]     b_reg;
    logic [DIV_R_W-1:0] rsi_num_reg, rsi_dvs_reg;
    logic [NUM_W-1:0]   num;
    logic               neg_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [A_W-1:0]     a_reg;
    logic               sat_reg;
    logic [SAT_W-1:0]   sat_lhs, sat_rhs;

    // dividers
    logic               rsi_busy, slope_busy;
    logic [DIV_Q_W-1:0] rsi_quo, slope_quo;

    // result register
    logic                      m_valid_reg, m_valid_next;
    logic [RSI_W-1:0]          rsi_out_reg, rsi_out_next;
    logic [SLOPE_W-1:0]        slope_out_reg, slope_out_next;
    logic                      svalid_out_reg, svalid_out_next;
    logic                      rsi_full, slope_full;
    logic [SLOPE_W-1:0]        mag_ext;

    // window pointers and first scan address
    always_comb begin
        wr_pos_next = (wr_pos_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                : wr_pos_reg + ADDR_W'(1);
        sample_count_next = (sample_count_reg < CNT_W'(WINDOW_DEPTH))
                            ? sample_count_reg + CNT_W'(1) : sample_count_reg;
        start_sum  = {2'b00, wr_pos_reg} + (ADDR_W+2)'(WINDOW_DEPTH + 1 - SCAN_LEN);
        start_addr = (start_sum >= (ADDR_W+2)'(WINDOW_DEPTH))
                     ? ADDR_W'(start_sum - (ADDR_W+2)'(WINDOW_DEPTH))
                     : ADDR_W'(start_sum);
        if (cmd.accept) begin
            rd_addr_next = start_addr;
        end else if (cmd.scan_rd) begin
            rd_addr_next = (rd_addr_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                      : rd_addr_reg + ADDR_W'(1);
        end else begin
            rd_addr_next = rd_addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pos_reg       <= '0;
            sample_count_reg <= '0;
            rd_vld_reg       <= 1'b0;
        end else begin
            if (cmd.accept) begin
                wr_pos_reg       <= wr_pos_next;
                sample_count_reg <= sample_count_next;
            end
            rd_vld_reg <= cmd.scan_rd;
        end
    end

    // window memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            window_mem[wr_pos_reg] <= s_close_price;
        end
        if (cmd.scan_rd) begin
            rd_data_reg <= window_mem[rd_addr_reg];
        end
        rd_addr_reg <= rd_addr_next;
        rd_pos_reg  <= cmd.scan_pos;
    end

    // x index within the slope window
    always_comb begin
        idx  = IDX_W'(rd_pos_reg - POS_W'(SLOPE_START));
        prod = (IDX_W+PRICE_W)'(idx) * (IDX_W+PRICE_W)'(rd_data_reg);
    end

    // gain, loss, sum y and sum xy over the scanned prices
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            gain_reg <= '0;
            loss_reg <= '0;
            sy_reg   <= '0;
            sxy_reg  <= '0;
        end else if (rd_vld_reg) begin
            prev_reg <= rd_data_reg;
            if (rd_pos_reg > POS_W'(RSI_START)) begin
                if (rd_data_reg > prev_reg) begin
                    gain_reg <= gain_reg + GL_W'(rd_data_reg - prev_reg);
                end else begin
                    loss_reg <= loss_reg + GL_W'(prev_reg - rd_data_reg);
                end
            end
            if (rd_pos_reg >= POS_W'(SLOPE_START)) begin
                sy_reg  <= sy_reg + SY_W'(rd_data_reg);
                sxy_reg <= sxy_reg + SXY_W'(prod);
            end
        end
    end

    // operand prep over four steps
    always_comb begin
        total_sum = gain_reg + loss_reg;
        num       = NUM_W'(nsxy_reg) - NUM_W'(sxsy_reg);
        sat_lhs   = SAT_W'(a_reg);
        sat_rhs   = SAT_W'(b_reg) << INT_BITS;
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep1) begin
            g100_reg  <= G100_W'(gain_reg) * G100_W'(RSI_PCT);
            total_reg <= total_sum;
            nsxy_reg  <= NSXY_W'(sxy_reg) * NSXY_W'(SLOPE_LEN);
            sxsy_reg  <= SXSY_W'(sy_reg) * SXSY_W'(SX);
            b_reg     <= B_W'(sy_reg) * B_W'(DEN);
        end
        if (cmd.prep2) begin
            rsi_num_reg <= (DIV_R_W'(g100_reg) << RSI_FRAC_BITS)
                           + DIV_R_W'(total_reg >> 1);
            rsi_dvs_reg <= DIV_R_W'(total_reg) << (RSI_Q_W - 1);
            neg_reg     <= num[NUM_W-1];
            mag_reg     <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        end
        if (cmd.prep3) begin
            a_reg <= A_W'(mag_reg) * A_W'(SLOPE_LEN);
        end
        if (cmd.prep4) begin
            sat_reg <= sat_lhs >= sat_rhs;
        end
    end

    // rsi ratio: first quotient bit weighs 2^22
    rsts_div u_rsi_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.prep4),
        .steps    (DIV_CNT_W'(RSI_Q_W)),
        .rem_init (rsi_num_reg),
        .dvs_init (rsi_dvs_reg),
        .busy     (rsi_busy),
        .quo      (rsi_quo)
    );

    // slope ratio: first quotient bit weighs 2^6, last 2^-24
    rsts_div u_slope_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.prep4),
        .steps    (DIV_CNT_W'(SLOPE_Q_W)),
        .rem_init (DIV_R_W'(a_reg)),
        .dvs_init (DIV_R_W'(b_reg) << (INT_BITS - 1)),
        .busy     (slope_busy),
        .quo      (slope_quo)
    );

    // final result selection
    always_comb begin
        rsi_full   = 32'(sample_count_reg) >= 32'(RSI_SPAN);
        slope_full = 32'(sample_count_reg) >= 32'(SLOPE_LEN);
        mag_ext    = SLOPE_W'(slope_quo[SLOPE_Q_W-1:0]);

        priority if (!rsi_full) begin
            rsi_out_next = RSI_W'(RSI_HALF_SCALE);
        end else if (loss_reg == '0) begin
            rsi_out_next = RSI_W'(RSI_FULL_SCALE);
        end else begin
            rsi_out_next = rsi_quo[RSI_W-1:0];
        end

        priority if (!slope_full || sy_reg == '0) begin
            slope_out_next  = '0;
            svalid_out_next = 1'b0;
        end else if (sat_reg) begin
            slope_out_next  = neg_reg ? {1'b1, {(SLOPE_W-1){1'b0}}}
                                      : {1'b0, {(SLOPE_W-1){1'b1}}};
            svalid_out_next = 1'b1;
        end else begin
            slope_out_next  = neg_reg ? SLOPE_W'(0) - mag_ext : mag_ext;
            svalid_out_next = 1'b1;
        end

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            rsi_out_reg    <= rsi_out_next;
            slope_out_reg  <= slope_out_next;
            svalid_out_reg <= svalid_out_next;
        end
    end

    assign sts.div_busy     = rsi_busy || slope_busy;
    assign sts.out_free     = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_rsi_value      = rsi_out_reg;
    assign m_relative_slope = $signed(slope_out_reg);
    assign m_slope_valid    = svalid_out_reg;

endmodule

@@ sv/rsts_ctrl.sv @@
// controller: sequences accept, window scan, operand prep, division and result load
module rsts_ctrl
    import rsts_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_DRAIN = 4'd2;
    localparam logic [3:0] ST_PREP1 = 4'd3;
    localparam logic [3:0] ST_PREP2 = 4'd4;
    localparam logic [3:0] ST_PREP3 = 4'd5;
    localparam logic [3:0] ST_PREP4 = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic [POS_W-1:0] SCAN_LAST = POS_W'(SCAN_LEN - 1);

    logic [3:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        cmd          = '0;
        cmd.scan_pos = pos_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    pos_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (pos_reg == SCAN_LAST) begin
                    state_next = ST_DRAIN;
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_PREP1;
            end
            ST_PREP1: begin
                cmd.prep1  = 1'b1;
                state_next = ST_PREP2;
            end
            ST_PREP2: begin
                cmd.prep2  = 1'b1;
                state_next = ST_PREP3;
            end
            ST_PREP3: begin
                cmd.prep3  = 1'b1;
                state_next = ST_PREP4;
            end
            ST_PREP4: begin
                cmd.prep4  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

`ifndef SYNTHESIS
    // a new beat never lands while a division is running
    a_accept_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !sts.div_busy)
        else $error("input beat accepted while divider busy");

    // result register is only loaded when it is free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten");

    // scan position steps by one each cycle
    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && pos_reg != SCAN_LAST)
        |=> (state_reg == ST_SCAN && pos_reg == $past(pos_reg) + POS_W'(1)))
        else $error("scan position skipped");

    // dividers start right after the last prep step
    a_div_started: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PREP4) |=> sts.div_busy)
        else $error("dividers did not start");
`endif

endmodule

@@ sv/price_rsi_and_trend_slope_core.sv @@
// top level of the price rsi and trend slope core
//
// One closing price per input beat on s_valid/s_ready/s_close_price; one result
// beat per price on m_valid/m_ready with m_rsi_value (unsigned Q7.16),
// m_relative_slope (signed Q7.24, saturated) and m_slope_valid.
// Each price is written into a 16-entry circular window, then the newest
// SCAN_LEN prices (15 here) are read back through the single memory read
// port, one per cycle, to build gain, loss, sum y and sum xy.
// Four prep steps form the division operands, then two serial dividers run
// side by side; the 31-step slope divider sets the length of that phase.
// A new price is taken only after the result of the previous one has been
// loaded into the result register.
// s_ready is high only while the core is idle; the result register lets the
// next price be accepted while the previous result still waits on m_ready.
// If the receiver stalls, the finished result waits in the dividers while the
// controller holds until the result register frees up; nothing is dropped.
// Synchronous active-low reset clears the window pointer and sample count,
// so both indicators restart from their not-full values.
module price_rsi_and_trend_slope_core
    import rsts_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [PRICE_W-1:0]        s_close_price,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [RSI_W-1:0]          m_rsi_value,
    output logic signed [SLOPE_W-1:0] m_relative_slope,
    output logic                      m_slope_valid
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    rsts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // window, arithmetic and result register
    rsts_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_close_price    (s_close_price),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rsi_value      (m_rsi_value),
        .m_relative_slope (m_relative_slope),
        .m_slope_valid    (m_slope_valid)
    );

endmodule
